### rtl/pktdisp_pkg.sv
// ----------------------------------------------------------------------------
// pktdisp_pkg
// Shared types and constants for the packet dispatcher.
// ----------------------------------------------------------------------------
package pktdisp_pkg;

    localparam int NUM_OUTPUTS = 16;
    localparam int DATA_WIDTH  = 64;

    // Flag fields and the destination index are fixed at 16 ports.
    localparam int FLAG_W     = 16;
    localparam int DEST_W     = 4;
    localparam int LOCK_W     = 5;
    localparam int PAYLOAD_W  = 64;
    localparam int KEEP_W     = 8;

    localparam int PORT_COUNT = (NUM_OUTPUTS > FLAG_W) ? FLAG_W :
                                (NUM_OUTPUTS < 1) ? 1 : NUM_OUTPUTS;

    localparam logic [FLAG_W-1:0] PORT_MASK =
        FLAG_W'((17'd1 << PORT_COUNT) - 17'd1);
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
        PAYLOAD_W'((65'd1 << DATA_WIDTH) - 65'd1);
    localparam logic [KEEP_W-1:0] KEEP_MASK =
        KEEP_W'((9'd1 << (DATA_WIDTH / 8)) - 9'd1);

    localparam logic [FLAG_W-1:0] PREF_ALL_ONES = 16'hFFFF;
    localparam logic [LOCK_W-1:0] LOCK_NONE     = '0;

    typedef struct packed {
        logic                 beat_valid;
        logic [PAYLOAD_W-1:0] beat_payload;
        logic [KEEP_W-1:0]    beat_keep;
        logic                 beat_last;
        logic [FLAG_W-1:0]    out_full_flags;
        logic [FLAG_W-1:0]    down_empty_flags;
        logic [FLAG_W-1:0]    down_notfull_flags;
    } t_in_word;

    typedef struct packed {
        logic                 out_valid;
        logic [DEST_W-1:0]    out_dest;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [KEEP_W-1:0]    out_keep;
        logic                 out_last;
    } t_out_word;

    // Dispatcher state carried between words.
    typedef struct packed {
        logic [LOCK_W-1:0] lock;   // 0 = unlocked, k+1 = locked to output k
        logic [FLAG_W-1:0] pref;   // preference mask
    } t_route_state;

endpackage

### rtl/packet_dispatcher_to_n_outputs.sv
// ----------------------------------------------------------------------------
// packet_dispatcher_to_n_outputs
// Steers whole packets from one beat stream to one of NUM_OUTPUTS outputs.
// ----------------------------------------------------------------------------
// Output path: an accepted word's steer result is registered (main or skid entry).
// Throughput: one word per cycle unless the input stalls; the steer decision is a
// single pass from the input word and the state registers into the result register.
// Output stall: the skid entry takes one more word behind a held result, then
// input stalls until the held word is taken and the skid word moves up.
// Reset (sync, active low): unlocked, preference all ones, output stage empty.
module packet_dispatcher_to_n_outputs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  pktdisp_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pktdisp_pkg::t_out_word o_out_word
);
    import pktdisp_pkg::*;

    // Routing state: lock and preference mask, updated on every accepted word.
    t_route_state r_state;
    t_route_state n_state;

    // Output stage: main result register and skid entry.
    logic      r_out_v;
    t_out_word r_out;
    logic      r_skid_v;
    t_out_word r_skid;

    t_out_word result;
    logic      in_take;
    logic      out_free;

    pktdisp_steer u_steer (
        .i_word   (i_in_word),
        .i_state  (r_state),
        .o_result (result),
        .o_state  (n_state)
    );

    // Input stalls only when both output entries are occupied.
    assign o_in_stall = r_skid_v;
    assign in_take    = i_in_valid && !r_skid_v;
    // Main register can load when empty or being drained this cycle.
    assign out_free   = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.lock <= LOCK_NONE;
            r_state.pref <= PREF_ALL_ONES;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= in_take;
            end
        end else if (in_take) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (in_take) begin
                r_out <= result;
            end
        end else if (in_take) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    // ---------------------------------------------------------------- checks
    // Skid entry is only used behind a held main entry.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid with main entry empty");

    // Lock never names a nonexistent output.
    a_lock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lock <= LOCK_W'(PORT_COUNT))
        else $error("lock beyond port count");

    // A forwarded last beat releases the lock.
    a_last_unlocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && result.out_valid && result.out_last |=> r_state.lock == LOCK_NONE)
        else $error("lock held after last beat");

    // Delivered destination is an existing output.
    a_dest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_valid |->
            LOCK_W'(o_out_word.out_dest) < LOCK_W'(PORT_COUNT))
        else $error("destination beyond port count");

endmodule

### rtl/pktdisp_steer.sv
// ----------------------------------------------------------------------------
// pktdisp_steer
// Per-word routing decision: picks the output, updates lock and preference.
// ----------------------------------------------------------------------------
module pktdisp_steer (
    input  pktdisp_pkg::t_in_word     i_word,
    input  pktdisp_pkg::t_route_state i_state,
    output pktdisp_pkg::t_out_word    o_result,
    output pktdisp_pkg::t_route_state o_state
);
    import pktdisp_pkg::*;

    logic [FLAG_W-1:0] full;
    logic [FLAG_W-1:0] empty;
    logic [FLAG_W-1:0] nfull;
    logic [FLAG_W-1:0] elig;
    logic              locked;
    logic [DEST_W-1:0] lock_idx;
    logic              found;
    logic [DEST_W-1:0] pick;
    logic              sent;
    logic [DEST_W-1:0] dest;

    assign full  = i_word.out_full_flags     & PORT_MASK;
    assign empty = i_word.down_empty_flags   & PORT_MASK;
    assign nfull = i_word.down_notfull_flags & PORT_MASK;
    assign elig  = ~full & i_state.pref & PORT_MASK;

    // out-of-range lock reads as unlocked
    assign locked   = (i_state.lock != LOCK_NONE) &&
                      (i_state.lock <= LOCK_W'(PORT_COUNT));
    assign lock_idx = DEST_W'(i_state.lock - LOCK_W'(1));

    // lowest eligible output
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = PORT_COUNT - 1; i >= 0; i--) begin
            if (elig[i]) begin
                found = 1'b1;
                pick  = DEST_W'(i);
            end
        end
    end

    always_comb begin
        if (locked) begin
            sent = i_word.beat_valid && !full[lock_idx];
            dest = lock_idx;
        end else begin
            sent = i_word.beat_valid && found;
            dest = pick;
        end
    end

    always_comb begin
        if (sent) begin
            o_state.lock = i_word.beat_last ? LOCK_NONE
                                            : LOCK_W'({1'b0, dest}) + LOCK_W'(1);
        end else if (locked) begin
            o_state.lock = i_state.lock;
        end else begin
            o_state.lock = LOCK_NONE;
        end

        if (empty != '0) begin
            o_state.pref = empty;
        end else if (nfull != '0) begin
            o_state.pref = nfull;
        end else begin
            o_state.pref = PREF_ALL_ONES;
        end
    end

    always_comb begin
        o_result.out_valid   = sent;
        o_result.out_dest    = sent ? dest : '0;
        o_result.out_payload = sent ? (i_word.beat_payload & PAYLOAD_MASK) : '0;
        o_result.out_keep    = sent ? (i_word.beat_keep & KEEP_MASK) : '0;
        o_result.out_last    = sent && i_word.beat_last;
    end

endmodule
